@@ hw/rtl/fbsc_pkg.sv @@
// Package for the frame buffer swap chain: command and result word types,
// action and register codes, field widths and register reset values.
// Used by frame_buffer_swap_chain_core; depends on nothing.
package fbsc_pkg;

  localparam int MAX_BUFFERS_DEF = 8;
  localparam int SIZE_ALIGN_DEF  = 32768;

  localparam int DIM_W   = 12;
  localparam int BYTE_W  = 3;
  localparam int BCNT_W  = 4;
  localparam int CFG_W   = 12;
  localparam int REG_W   = 3;
  localparam int SIZE_W  = 25;
  localparam int BASE_W  = 30;
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 12;

  localparam int DIM_MAX   = 2048;
  localparam int BYTES_MAX = 4;

  localparam int DEF_FRAME_WIDTH  = 320;
  localparam int DEF_FRAME_HEIGHT = 240;
  localparam int DEF_COLOR_BYTES  = 4;
  localparam int DEF_DEPTH_ENABLE = 1;
  localparam int DEF_DEPTH_BYTES  = 4;
  localparam int DEF_BUFFER_COUNT = 2;

  typedef enum logic [2:0] {
    ACT_RESTART      = 3'd0,
    ACT_DRAW_DONE    = 3'd1,
    ACT_DISPLAY_NEXT = 3'd2,
    ACT_DRAW_NEXT    = 3'd3,
    ACT_SWAP         = 3'd4,
    ACT_QUERY        = 3'd5
  } fbsc_action_e;

  typedef enum logic [REG_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COLOR_BYTES  = 3'd2,
    REG_DEPTH_ENABLE = 3'd3,
    REG_DEPTH_BYTES  = 3'd4,
    REG_BUFFER_COUNT = 3'd5
  } fbsc_reg_e;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] buffer_index;
  } fbsc_in_t;

  typedef struct packed {
    logic [2:0]        display_buffer;
    logic [2:0]        draw_buffer;
    logic [BASE_W-1:0] display_base;
    logic [BASE_W-1:0] draw_base;
    logic [BASE_W-1:0] queried_base;
    logic [BASE_W-1:0] depth_base;
    logic [BASE_W-1:0] texture_base;
    logic              draw_available;
    logic              display_available;
    logic [3:0]        free_buffers;
    logic [2:0]        complete_buffers;
  } fbsc_out_t;

endpackage

@@ hw/rtl/frame_buffer_swap_chain_core.sv @@
// Frame buffer swap chain: ring bookkeeping and buffer base computation
// around one shared 25x12 multiplier under a small sequencer.
// Depends on fbsc_pkg.
//
//  channel   ports                                   handshake
//  command   start_i, cmd_i                          taken when start_i && !busy_o
//  result    done_o, result_o                        one-cycle strobe, no back pressure
//  config    cfg_we_i, cfg_idx_i, cfg_data_i         written when cfg_we_i is high
//
// An event or query runs four multiplier steps while busy_o is high; the result
// word strobes once the sequencer is back in idle, and the next command can be
// taken while it strobes, so a command is not taken before the last one is done.
// A restart adds three steps for the frame and depth sizes ahead of those four,
// and busy_o stays high through all of them before the word strobes.
// The steps run one after another, as they share the single multiplier.
// Reset leaves the state of a restart with the register reset values.
// SIZE_ALIGN must be a power of two; rounding is an add and a mask.
module frame_buffer_swap_chain_core #(
  parameter int MAX_BUFFERS = fbsc_pkg::MAX_BUFFERS_DEF,
  parameter int SIZE_ALIGN  = fbsc_pkg::SIZE_ALIGN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  fbsc_pkg::fbsc_in_t             cmd_i,
  output logic                           busy_o,
  output logic                           done_o,
  output fbsc_pkg::fbsc_out_t            result_o,
  input  logic                           cfg_we_i,
  input  logic [fbsc_pkg::REG_W-1:0]     cfg_idx_i,
  input  logic [fbsc_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_BUFFERS + 1);
  localparam int IDX_W = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int SW    = fbsc_pkg::SIZE_W;
  localparam int BW    = fbsc_pkg::BASE_W;
  localparam int AW    = fbsc_pkg::MUL_A_W;
  localparam int BMW   = fbsc_pkg::MUL_B_W;
  localparam int PW    = AW + BMW;

  localparam int RST_RING = (fbsc_pkg::DEF_BUFFER_COUNT == 0) ? 1 :
      ((fbsc_pkg::DEF_BUFFER_COUNT > MAX_BUFFERS) ? MAX_BUFFERS : fbsc_pkg::DEF_BUFFER_COUNT);
  localparam int RST_DRAW = (RST_RING > 1) ? 1 : 0;
  localparam int RST_FREE = (RST_RING > 2) ? RST_RING - 2 : 0;
  localparam int RST_FRAME =
      ((fbsc_pkg::DEF_FRAME_WIDTH * fbsc_pkg::DEF_FRAME_HEIGHT * fbsc_pkg::DEF_COLOR_BYTES
        + SIZE_ALIGN - 1) / SIZE_ALIGN) * SIZE_ALIGN;
  localparam int RST_DEPTH = (fbsc_pkg::DEF_DEPTH_ENABLE == 0) ? 0 :
      ((fbsc_pkg::DEF_FRAME_WIDTH * fbsc_pkg::DEF_FRAME_HEIGHT * fbsc_pkg::DEF_DEPTH_BYTES
        + SIZE_ALIGN - 1) / SIZE_ALIGN) * SIZE_ALIGN;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WH, ST_COLOR, ST_DEPTH, ST_DBASE, ST_DISP, ST_DRAW, ST_QUERY
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [fbsc_pkg::DIM_W-1:0]  width_q, width_d;
  logic [fbsc_pkg::DIM_W-1:0]  height_q, height_d;
  logic [fbsc_pkg::BYTE_W-1:0] cbytes_q, cbytes_d;
  logic                        den_q, den_d;
  logic [fbsc_pkg::BYTE_W-1:0] dbytes_q, dbytes_d;
  logic [fbsc_pkg::BCNT_W-1:0] bcount_q, bcount_d;

  // Ring state latched at restart and updated by events.
  logic [CNT_W-1:0] ring_q, ring_d;
  logic [IDX_W-1:0] disp_q, disp_d;
  logic [IDX_W-1:0] draw_q, draw_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [CNT_W-1:0] comp_q, comp_d;
  logic [SW-1:0]    frame_q, frame_d;
  logic [SW-1:0]    dtotal_q, dtotal_d;

  // Working registers of the sequencer.
  logic [SW-1:0]     wh_q, wh_d;
  logic [IDX_W-1:0]  qidx_q, qidx_d;
  logic              isq_q, isq_d;
  logic              done_q, done_d;
  fbsc_pkg::fbsc_out_t res_q, res_d;

  logic [AW-1:0]  mul_a;
  logic [BMW-1:0] mul_b;
  logic [PW-1:0]  prod;
  logic [SW-1:0]  aligned;

  function automatic logic [fbsc_pkg::DIM_W-1:0] clamp_dim(
      input logic [fbsc_pkg::DIM_W-1:0] v);
    if (v == '0) return fbsc_pkg::DIM_W'(1);
    if (int'(v) > fbsc_pkg::DIM_MAX) return fbsc_pkg::DIM_W'(fbsc_pkg::DIM_MAX);
    return v;
  endfunction

  function automatic logic [fbsc_pkg::BYTE_W-1:0] clamp_bytes(
      input logic [fbsc_pkg::BYTE_W-1:0] v);
    if (v == '0) return fbsc_pkg::BYTE_W'(1);
    if (int'(v) > fbsc_pkg::BYTES_MAX) return fbsc_pkg::BYTE_W'(fbsc_pkg::BYTES_MAX);
    return v;
  endfunction

  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] ring);
    logic [CNT_W:0] inc;
    inc = (CNT_W + 1)'(i) + 1'b1;
    if (inc >= (CNT_W + 1)'(ring)) return '0;
    return IDX_W'(inc);
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_WH: begin
        mul_a = AW'(clamp_dim(width_q));
        mul_b = BMW'(clamp_dim(height_q));
      end
      ST_COLOR: begin
        mul_a = AW'(wh_q);
        mul_b = BMW'(clamp_bytes(cbytes_q));
      end
      ST_DEPTH: begin
        mul_a = AW'(wh_q);
        mul_b = BMW'(clamp_bytes(dbytes_q));
      end
      ST_DBASE: begin
        mul_a = AW'(frame_q);
        mul_b = BMW'(ring_q);
      end
      ST_DISP: begin
        mul_a = AW'(frame_q);
        mul_b = BMW'(disp_q);
      end
      ST_DRAW: begin
        mul_a = AW'(frame_q);
        mul_b = BMW'(draw_q);
      end
      ST_QUERY: begin
        mul_a = AW'(frame_q);
        mul_b = BMW'(qidx_q);
      end
      default: ;
    endcase
  end

  assign prod    = PW'(mul_a) * PW'(mul_b);
  assign aligned = (prod[SW-1:0] + SW'(SIZE_ALIGN - 1)) & ~SW'(SIZE_ALIGN - 1);

  always_comb begin
    logic [CNT_W-1:0] ring_c;
    logic             do_dd;
    logic             do_dn;
    logic             do_wn;

    state_d  = state_q;
    width_d  = width_q;
    height_d = height_q;
    cbytes_d = cbytes_q;
    den_d    = den_q;
    dbytes_d = dbytes_q;
    bcount_d = bcount_q;
    ring_d   = ring_q;
    disp_d   = disp_q;
    draw_d   = draw_q;
    free_d   = free_q;
    comp_d   = comp_q;
    frame_d  = frame_q;
    dtotal_d = dtotal_q;
    wh_d     = wh_q;
    qidx_d   = qidx_q;
    isq_d    = isq_q;
    res_d    = res_q;
    done_d   = 1'b0;

    if (bcount_q == '0) begin
      ring_c = CNT_W'(1);
    end else if (int'(bcount_q) > MAX_BUFFERS) begin
      ring_c = CNT_W'(MAX_BUFFERS);
    end else begin
      ring_c = CNT_W'(bcount_q);
    end

    do_dd = (cmd_i.action == fbsc_pkg::ACT_DRAW_DONE) || (cmd_i.action == fbsc_pkg::ACT_SWAP);
    do_dn = (cmd_i.action == fbsc_pkg::ACT_DISPLAY_NEXT) ||
            (cmd_i.action == fbsc_pkg::ACT_SWAP);
    do_wn = (cmd_i.action == fbsc_pkg::ACT_DRAW_NEXT) || (cmd_i.action == fbsc_pkg::ACT_SWAP);

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fbsc_pkg::REG_FRAME_WIDTH:  width_d  = cfg_data_i[fbsc_pkg::DIM_W-1:0];
        fbsc_pkg::REG_FRAME_HEIGHT: height_d = cfg_data_i[fbsc_pkg::DIM_W-1:0];
        fbsc_pkg::REG_COLOR_BYTES:  cbytes_d = cfg_data_i[fbsc_pkg::BYTE_W-1:0];
        fbsc_pkg::REG_DEPTH_ENABLE: den_d    = cfg_data_i[0];
        fbsc_pkg::REG_DEPTH_BYTES:  dbytes_d = cfg_data_i[fbsc_pkg::BYTE_W-1:0];
        fbsc_pkg::REG_BUFFER_COUNT: bcount_d = cfg_data_i[fbsc_pkg::BCNT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          isq_d = (cmd_i.action == fbsc_pkg::ACT_QUERY);
          if (int'(cmd_i.buffer_index) > int'(ring_q) - 1) begin
            qidx_d = IDX_W'(ring_q - 1'b1);
          end else begin
            qidx_d = IDX_W'(cmd_i.buffer_index);
          end
          state_d = ST_DBASE;
          if (cmd_i.action == fbsc_pkg::ACT_RESTART) begin
            ring_d  = ring_c;
            disp_d  = '0;
            draw_d  = (ring_c > CNT_W'(1)) ? IDX_W'(1) : '0;
            free_d  = (ring_c > CNT_W'(2)) ? ring_c - CNT_W'(2) : '0;
            comp_d  = '0;
            state_d = ST_WH;
          end else begin
            // Swap applies draw done, display next and draw next in that order.
            if (do_dd && (comp_d < ring_q - 1'b1)) begin
              comp_d = comp_d + 1'b1;
            end
            if (do_dn && (comp_d != '0)) begin
              disp_d = next_index(disp_d, ring_q);
              comp_d = comp_d - 1'b1;
              if (free_d < ring_q) begin
                free_d = free_d + 1'b1;
              end
            end
            if (do_wn && (free_d != '0)) begin
              draw_d = next_index(draw_d, ring_q);
              free_d = free_d - 1'b1;
            end
          end
        end
      end
      ST_WH: begin
        wh_d    = prod[SW-1:0];
        state_d = ST_COLOR;
      end
      ST_COLOR: begin
        frame_d = aligned;
        state_d = ST_DEPTH;
      end
      ST_DEPTH: begin
        dtotal_d = den_q ? aligned : '0;
        state_d  = ST_DBASE;
      end
      ST_DBASE: begin
        res_d.depth_base = prod[BW-1:0];
        state_d          = ST_DISP;
      end
      ST_DISP: begin
        res_d.display_base = prod[BW-1:0];
        res_d.texture_base = res_q.depth_base + BW'(dtotal_q);
        state_d            = ST_DRAW;
      end
      ST_DRAW: begin
        res_d.draw_base = prod[BW-1:0];
        state_d         = ST_QUERY;
      end
      ST_QUERY: begin
        res_d.queried_base      = isq_q ? prod[BW-1:0] : '0;
        res_d.display_buffer    = 3'(disp_q);
        res_d.draw_buffer       = 3'(draw_q);
        res_d.draw_available    = (free_q != '0);
        res_d.display_available = (comp_q != '0);
        res_d.free_buffers      = 4'(free_q);
        res_d.complete_buffers  = 3'(comp_q);
        done_d                  = 1'b1;
        state_d                 = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      width_q  <= fbsc_pkg::DIM_W'(fbsc_pkg::DEF_FRAME_WIDTH);
      height_q <= fbsc_pkg::DIM_W'(fbsc_pkg::DEF_FRAME_HEIGHT);
      cbytes_q <= fbsc_pkg::BYTE_W'(fbsc_pkg::DEF_COLOR_BYTES);
      den_q    <= 1'(fbsc_pkg::DEF_DEPTH_ENABLE);
      dbytes_q <= fbsc_pkg::BYTE_W'(fbsc_pkg::DEF_DEPTH_BYTES);
      bcount_q <= fbsc_pkg::BCNT_W'(fbsc_pkg::DEF_BUFFER_COUNT);
      ring_q   <= CNT_W'(RST_RING);
      disp_q   <= '0;
      draw_q   <= IDX_W'(RST_DRAW);
      free_q   <= CNT_W'(RST_FREE);
      comp_q   <= '0;
      frame_q  <= SW'(RST_FRAME);
      dtotal_q <= SW'(RST_DEPTH);
      wh_q     <= '0;
      qidx_q   <= '0;
      isq_q    <= 1'b0;
      done_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      width_q  <= width_d;
      height_q <= height_d;
      cbytes_q <= cbytes_d;
      den_q    <= den_d;
      dbytes_q <= dbytes_d;
      bcount_q <= bcount_d;
      ring_q   <= ring_d;
      disp_q   <= disp_d;
      draw_q   <= draw_d;
      free_q   <= free_d;
      comp_q   <= comp_d;
      frame_q  <= frame_d;
      dtotal_q <= dtotal_d;
      wh_q     <= wh_d;
      qidx_q   <= qidx_d;
      isq_q    <= isq_d;
      done_q   <= done_d;
      res_q    <= res_d;
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result word without a preceding busy phase");

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not start the sequencer");

  a_comp_below_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_q < ring_q)
    else $error("complete count reached the ring size");

  a_free_within_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= ring_q)
    else $error("free count above the ring size");

  a_index_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W'(disp_q) < ring_q) && (CNT_W'(draw_q) < ring_q))
    else $error("buffer index outside the ring");
`endif

endmodule
